// ===== rtl/core/affinv_pkg.sv =====
package affinv_pkg;

    // Q16.16 by default
    localparam int DEF_FRAC_BITS = 16;

    // Coefficient width and quotient bits developed by the divider
    localparam int COEF_W = 32;
    localparam int QUO_W  = 32;
    localparam int MAG_W  = 64;

    // Saturation limits of a signed coefficient
    localparam logic [COEF_W-1:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [COEF_W-1:0] SAT_NEG = 32'h8000_0000;

    // Sign-magnitude value, magnitude up to 2^63
    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
    } sm_t;

    // Numerators and divisor handed from the product stage to the dividers
    typedef struct packed {
        sm_t det;
        sm_t num_a;
        sm_t num_b;
        sm_t num_c;
        sm_t num_d;
        sm_t num_e;
        sm_t num_f;
    } affinv_terms_t;

endpackage

// ===== rtl/core/affinv_mul.sv =====
module affinv_mul (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       en,
    input  logic                       in_vld,
    input  logic [31:0]                a,
    input  logic [31:0]                b,
    input  logic [31:0]                c,
    input  logic [31:0]                d,
    input  logic [31:0]                e,
    input  logic [31:0]                f,
    output logic                       out_vld,
    output affinv_pkg::affinv_terms_t  terms
);

    // Two's complement coefficient to sign-magnitude
    function automatic affinv_pkg::sm_t sm_of(input logic [31:0] x);
        logic [32:0]       xe;
        affinv_pkg::sm_t   r;
        xe = {x[31], x};
        if (x[31]) begin
            xe = -xe;
        end
        r.neg = x[31];
        r.mag = 64'(xe);
        return r;
    endfunction

    // Signed difference of two products to sign-magnitude
    function automatic affinv_pkg::sm_t sm_diff(input logic signed [63:0] p,
                                               input logic signed [63:0] q);
        logic signed [64:0] dd;
        affinv_pkg::sm_t    r;
        dd = 65'(p) - 65'(q);
        r.neg = dd[64];
        r.mag = dd[64] ? 64'(-dd) : dd[63:0];
        return r;
    endfunction

    logic signed [31:0] sa, sb, sc, sd, se, sf;
    logic signed [63:0] p_ae_reg, p_bd_reg, p_bf_reg, p_ec_reg, p_cd_reg, p_af_reg;
    logic [31:0]        a_reg, b_reg, d_reg, e_reg;
    logic               vld1_reg, vld2_reg;
    affinv_pkg::affinv_terms_t terms_reg, terms_next;

    assign sa = a;
    assign sb = b;
    assign sc = c;
    assign sd = d;
    assign se = e;
    assign sf = f;

    // Stage 1: register the six products
    always_ff @(posedge aclk) begin
        if (en) begin
            p_ae_reg <= sa * se;
            p_bd_reg <= sb * sd;
            p_bf_reg <= sb * sf;
            p_ec_reg <= se * sc;
            p_cd_reg <= sc * sd;
            p_af_reg <= sa * sf;
            a_reg    <= a;
            b_reg    <= b;
            d_reg    <= d;
            e_reg    <= e;
        end
    end

    // Stage 2: determinant, translation numerators, signed numerators
    always_comb begin
        terms_next.det   = sm_diff(p_ae_reg, p_bd_reg);
        terms_next.num_a = sm_of(e_reg);
        terms_next.num_b = sm_of(b_reg);
        terms_next.num_b.neg = ~terms_next.num_b.neg;
        terms_next.num_c = sm_diff(p_bf_reg, p_ec_reg);
        terms_next.num_d = sm_of(d_reg);
        terms_next.num_d.neg = ~terms_next.num_d.neg;
        terms_next.num_e = sm_of(a_reg);
        terms_next.num_f = sm_diff(p_cd_reg, p_af_reg);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            terms_reg <= terms_next;
        end
    end

    // Advance valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
        end else if (en) begin
            vld1_reg <= in_vld;
            vld2_reg <= vld1_reg;
        end
    end

    assign out_vld = vld2_reg;
    assign terms   = terms_reg;

endmodule

// ===== rtl/core/affinv_div.sv =====
module affinv_div #(
    parameter int FRAC_BITS = affinv_pkg::DEF_FRAC_BITS,
    parameter int SHIFT     = 2 * affinv_pkg::DEF_FRAC_BITS
) (
    input  logic                          aclk,
    input  logic                          en,
    input  affinv_pkg::sm_t               num,
    input  affinv_pkg::sm_t               den,
    output logic [affinv_pkg::QUO_W-1:0]  quo,
    output logic                          big,
    output logic                          neg
);

    localparam int QW = affinv_pkg::QUO_W;
    localparam int MW = affinv_pkg::MAG_W;
    localparam int NW = MW + 2 * FRAC_BITS;
    localparam int CW = (NW > MW + QW) ? NW : MW + QW;

    logic [NW-1:0] num_ext;
    logic          big_next;

    logic [MW-1:0] rem_reg [0:QW];
    logic [QW-1:0] ql_reg  [0:QW];
    logic [MW-1:0] den_reg [0:QW];
    logic          big_reg [0:QW];
    logic          neg_reg [0:QW];

    // Scale numerator; quotient of 2^32 or more always saturates
    assign num_ext  = NW'(num.mag) << SHIFT;
    assign big_next = CW'(num_ext) >= (CW'(den.mag) << QW);

    // Entry stage: high part seeds the remainder, low part shifts in
    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= MW'(num_ext >> QW);
            ql_reg[0]  <= num_ext[QW-1:0];
            den_reg[0] <= den.mag;
            big_reg[0] <= big_next;
            neg_reg[0] <= num.neg ^ den.neg;
        end
    end

    // One restoring step per stage
    for (genvar k = 0; k < QW; k++) begin : g_step
        logic [MW:0] trial;
        logic        ge;

        assign trial = {rem_reg[k], ql_reg[k][QW-1]};
        assign ge    = trial >= {1'b0, den_reg[k]};

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k+1] <= ge ? MW'(trial - {1'b0, den_reg[k]}) : trial[MW-1:0];
                ql_reg[k+1]  <= {ql_reg[k][QW-2:0], ge};
                den_reg[k+1] <= den_reg[k];
                big_reg[k+1] <= big_reg[k];
                neg_reg[k+1] <= neg_reg[k];
            end
        end
    end

    assign quo = ql_reg[QW];
    assign big = big_reg[QW];
    assign neg = neg_reg[QW];

endmodule

// ===== rtl/core/affine_matrix_inverse.sv =====
// Affine 2x3 matrix inverse, signed fixed point with FRAC_BITS fraction bits.
// Input channel s_*: one request carries the six coefficients a..f of the
// matrix [a b c; d e f; 0 0 1]. Output channel m_*: the six inverse
// coefficients in m_tdata, and in m_tuser[0] a flag that is 1 when the
// determinant is nonzero. A singular matrix gives flag 0 and all zeros.
// Each quotient is truncated toward zero and saturated to 32 bits.
// The pipeline has two multiply stages, one scaling and range-check stage,
// 32 restoring divide stages (one quotient bit each) and an output register.
// A new request is taken every cycle unless a waiting result is stalled;
// the six dividers run in parallel and share the determinant as divisor.
// When the receiver holds m_tready low while a result waits, the whole
// pipeline freezes and s_tready drops; nothing is lost or repeated, and
// flow resumes in the cycle m_tready returns.
// Reset clears every valid flag and nothing else; data registers are not reset.
module affine_matrix_inverse #(
    parameter int FRAC_BITS = affinv_pkg::DEF_FRAC_BITS
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [191:0] s_tdata,   // m_a, m_b, m_c, m_d, m_e, m_f
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [191:0] m_tdata,   // inv_a, inv_b, inv_c, inv_d, inv_e, inv_f
    output logic [0:0]   m_tuser    // invertible
);

    localparam int QW  = affinv_pkg::QUO_W;
    localparam int LAT = QW + 1;

    logic                      en;
    logic                      mul_vld;
    affinv_pkg::affinv_terms_t terms;

    logic [QW-1:0] quo [0:5];
    logic          big [0:5];
    logic          neg [0:5];

    logic          vld_reg  [0:LAT-1];
    logic          zero_reg [0:LAT-1];
    logic          out_vld_reg;
    logic          inv_ok_reg, inv_ok_next;
    logic [191:0]  out_data_reg, out_data_next;

    // Freeze the pipeline only while a result waits on a stalled receiver
    assign en       = !out_vld_reg || m_tready;
    assign s_tready = en;

    affinv_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .in_vld  (s_tvalid),
        .a       (s_tdata[31:0]),
        .b       (s_tdata[63:32]),
        .c       (s_tdata[95:64]),
        .d       (s_tdata[127:96]),
        .e       (s_tdata[159:128]),
        .f       (s_tdata[191:160]),
        .out_vld (mul_vld),
        .terms   (terms)
    );

    affinv_div #(.FRAC_BITS(FRAC_BITS), .SHIFT(2 * FRAC_BITS)) u_div_a (
        .aclk(aclk), .en(en), .num(terms.num_a), .den(terms.det),
        .quo(quo[0]), .big(big[0]), .neg(neg[0])
    );
    affinv_div #(.FRAC_BITS(FRAC_BITS), .SHIFT(2 * FRAC_BITS)) u_div_b (
        .aclk(aclk), .en(en), .num(terms.num_b), .den(terms.det),
        .quo(quo[1]), .big(big[1]), .neg(neg[1])
    );
    affinv_div #(.FRAC_BITS(FRAC_BITS), .SHIFT(FRAC_BITS)) u_div_c (
        .aclk(aclk), .en(en), .num(terms.num_c), .den(terms.det),
        .quo(quo[2]), .big(big[2]), .neg(neg[2])
    );
    affinv_div #(.FRAC_BITS(FRAC_BITS), .SHIFT(2 * FRAC_BITS)) u_div_d (
        .aclk(aclk), .en(en), .num(terms.num_d), .den(terms.det),
        .quo(quo[3]), .big(big[3]), .neg(neg[3])
    );
    affinv_div #(.FRAC_BITS(FRAC_BITS), .SHIFT(2 * FRAC_BITS)) u_div_e (
        .aclk(aclk), .en(en), .num(terms.num_e), .den(terms.det),
        .quo(quo[4]), .big(big[4]), .neg(neg[4])
    );
    affinv_div #(.FRAC_BITS(FRAC_BITS), .SHIFT(FRAC_BITS)) u_div_f (
        .aclk(aclk), .en(en), .num(terms.num_f), .den(terms.det),
        .quo(quo[5]), .big(big[5]), .neg(neg[5])
    );

    // Carry valid and singular flags alongside the dividers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LAT; i++) begin
                vld_reg[i] <= 1'b0;
            end
        end else if (en) begin
            vld_reg[0] <= mul_vld;
            for (int i = 1; i < LAT; i++) begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            zero_reg[0] <= (terms.det.mag == '0);
            for (int i = 1; i < LAT; i++) begin
                zero_reg[i] <= zero_reg[i-1];
            end
        end
    end

    // Apply sign and saturation; zero everything for a singular matrix
    always_comb begin
        out_data_next = '0;
        inv_ok_next   = !zero_reg[LAT-1];
        if (inv_ok_next) begin
            for (int i = 0; i < 6; i++) begin
                if (neg[i]) begin
                    if (big[i] || (quo[i] > affinv_pkg::SAT_NEG)) begin
                        out_data_next[i*QW +: QW] = affinv_pkg::SAT_NEG;
                    end else begin
                        out_data_next[i*QW +: QW] = -quo[i];
                    end
                end else begin
                    if (big[i] || quo[i][QW-1]) begin
                        out_data_next[i*QW +: QW] = affinv_pkg::SAT_POS;
                    end else begin
                        out_data_next[i*QW +: QW] = quo[i];
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_data_reg <= out_data_next;
            inv_ok_reg   <= inv_ok_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (en) begin
            out_vld_reg <= vld_reg[LAT-1];
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = inv_ok_reg;

    // A singular result carries all-zero coefficients
    a_singular_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
        else $error("singular result with nonzero coefficients");

    // Input is taken exactly when the output side can move
    a_ready_rule: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("s_tready out of step with output stall");

    // No result appears right after reset
    a_reset_empty: assert property (@(posedge aclk)
        (aresetn && $past(!aresetn)) |-> !m_tvalid)
        else $error("result valid after reset");

    // A stalled result holds its flag
    a_hold_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable(m_tuser))
        else $error("invertible flag changed under stall");

endmodule

// ===== tb/tb_affine_matrix_inverse.sv =====
module tb_affine_matrix_inverse;

    localparam int FRAC   = affinv_pkg::DEF_FRAC_BITS;
    localparam int CW     = affinv_pkg::COEF_W;
    localparam int LAT    = 36;
    localparam int WD_MAX = 20000;

    localparam logic [CW-1:0] SAT_POS = affinv_pkg::SAT_POS;
    localparam logic [CW-1:0] SAT_NEG = affinv_pkg::SAT_NEG;

    typedef struct packed {
        logic [CW-1:0] f, e, d, c, b, a;
    } matrix_t;

    typedef struct {
        logic [CW-1:0] coef [6];
        logic          invertible;
    } inverse_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [191:0] s_tdata = '0;   // m_a, m_b, m_c, m_d, m_e, m_f
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [191:0] m_tdata;        // inv_a, inv_b, inv_c, inv_d, inv_e, inv_f
    logic [0:0]   m_tuser;        // invertible

    string    coef_names [6] = '{"inv_a", "inv_b", "inv_c", "inv_d", "inv_e", "inv_f"};
    inverse_t inverse_q[$];
    int       errors = 0;
    int       idle_send = 0;
    int       idle_recv = 0;
    int       hold_recv = 0;
    int       quiet_cycles = 0;

    affine_matrix_inverse u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Truncating divide of num * 2^sh by det, saturated to 32 bits
    function automatic logic [CW-1:0] sat_quot(logic signed [129:0] num, int sh,
                                              logic signed [129:0] det);
        logic signed [129:0] q;
        q = (num <<< sh) / det;
        if (q > 130'sh7FFF_FFFF) return SAT_POS;
        if (q < -130'sh8000_0000) return SAT_NEG;
        return q[CW-1:0];
    endfunction

    function automatic inverse_t invert(matrix_t m);
        logic signed [129:0] a, b, c, d, e, f, det;
        inverse_t r;
        a = $signed(m.a); b = $signed(m.b); c = $signed(m.c);
        d = $signed(m.d); e = $signed(m.e); f = $signed(m.f);
        det = a * e - b * d;
        r.invertible = (det != 0);
        if (det == 0) begin
            foreach (r.coef[k]) r.coef[k] = '0;
            return r;
        end
        r.coef[0] = sat_quot(e, 2 * FRAC, det);
        r.coef[1] = sat_quot(-b, 2 * FRAC, det);
        r.coef[2] = sat_quot(b * f - e * c, FRAC, det);
        r.coef[3] = sat_quot(-d, 2 * FRAC, det);
        r.coef[4] = sat_quot(a, 2 * FRAC, det);
        r.coef[5] = sat_quot(c * d - a * f, FRAC, det);
        return r;
    endfunction

    // Offer one request, honoring the sender idle rate; hold valid for the next one
    task automatic send_matrix(matrix_t m);
        while ($urandom_range(99) < idle_send) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= m;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        inverse_q.push_back(invert(m));
        @(negedge aclk);
    endtask

    // Drop valid and wait for every expected result
    task automatic drain();
        s_tvalid <= 1'b0;
        while (inverse_q.size() != 0) @(negedge aclk);
    endtask

    function automatic logic [CW-1:0] edge_coef();
        case ($urandom_range(9))
            0: return SAT_POS;
            1: return SAT_NEG;
            2: return '0;
            3: return 32'h0001_0000;
            4: return 32'hFFFF_0000;
            5: return 32'h0000_0001;
            6: return 32'hFFFF_FFFF;
            7: return $urandom_range(65535) - 32768;
            default: return $urandom;
        endcase
    endfunction

    function automatic matrix_t random_matrix();
        matrix_t m;
        m = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        case ($urandom_range(5))
            0: begin m.a = edge_coef(); m.b = edge_coef(); m.c = edge_coef();
                   m.d = edge_coef(); m.e = edge_coef(); m.f = edge_coef(); end
            1: begin m.d = m.a; m.e = m.b; end                 // singular rows
            2: begin m.a = $urandom_range(131071) - 65536;     // near-singular scale
                   m.e = $urandom_range(131071) - 65536;
                   m.b = $urandom_range(255); m.d = $urandom_range(255); end
            3: begin m.a = 32'h0001_0000 + $urandom_range(4095);
                   m.e = 32'h0001_0000 - $urandom_range(4095);
                   m.b = $urandom_range(8191) - 4096; m.d = $urandom_range(8191) - 4096; end
            default: ;
        endcase
        return m;
    endfunction

    task automatic test_directed();
        matrix_t m;
        send_matrix({32'd0, 32'h0001_0000, 32'd0, 32'd0, 32'd0, 32'h0001_0000});
        send_matrix({32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0});
        send_matrix({SAT_POS, SAT_POS, SAT_POS, SAT_POS, SAT_POS, SAT_POS});
        send_matrix({SAT_NEG, SAT_NEG, SAT_NEG, SAT_NEG, SAT_NEG, SAT_NEG});
        send_matrix({SAT_POS, 32'd1, 32'd0, 32'd0, SAT_NEG, 32'd1});
        send_matrix({SAT_NEG, 32'd1, SAT_POS, 32'd0, SAT_POS, 32'd1});
        send_matrix({32'd5, 32'd3, 32'd0, 32'd2, 32'd4, 32'd7});
        send_matrix({32'h0003_0000, 32'h0004_0000, 32'hFFFE_0000, 32'h0002_0000,
                     32'h0001_8000, 32'h0002_0000});
        send_matrix({SAT_POS, SAT_NEG, SAT_POS, SAT_POS, SAT_NEG, SAT_POS});
        send_matrix({32'd1, 32'd0, 32'd1, 32'd0, 32'd0, SAT_NEG});
        send_matrix({32'h0100_0000, 32'd0, 32'hFF00_0000, 32'd0, 32'd0, 32'h0100_0000});
        send_matrix({32'd0, 32'd1, 32'd0, 32'd1, 32'd0, 32'd0});
        send_matrix({32'd0, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'd0});
        for (int k = 0; k < 8; k++) begin
            m = {6{32'h0}};
            m.a = edge_coef(); m.e = edge_coef(); m.b = edge_coef(); m.d = edge_coef();
            m.c = edge_coef(); m.f = edge_coef();
            send_matrix(m);
        end
        drain();
    endtask

    task automatic test_random(int count, int s_idle, int r_idle);
        idle_send = s_idle;
        idle_recv = r_idle;
        for (int k = 0; k < count; k++) send_matrix(random_matrix());
        drain();
    endtask

    task automatic test_backpressure();
        idle_send = 0;
        idle_recv = 0;
        hold_recv = 200;
        for (int k = 0; k < 120; k++) send_matrix(random_matrix());
        drain();
    endtask

    // Drive the receiver ready, with an optional long hold-off
    always @(negedge aclk) begin
        if (hold_recv > 0) begin
            m_tready  <= 1'b0;
            hold_recv <= hold_recv - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= idle_recv);
        end
    end

    // Check each accepted result against the oldest expectation
    always @(posedge aclk) begin
        inverse_t exp_inv;
        logic [CW-1:0] got;
        if (aresetn && m_tvalid && m_tready) begin
            if (inverse_q.size() == 0) begin
                $error("result with no request pending");
                errors++;
            end else begin
                exp_inv = inverse_q.pop_front();
                for (int k = 0; k < 6; k++) begin
                    got = m_tdata[k*CW +: CW];
                    if (got !== exp_inv.coef[k]) begin
                        $error("%s expected %h got %h", coef_names[k], exp_inv.coef[k], got);
                        errors++;
                    end
                end
                if (m_tuser[0] !== exp_inv.invertible) begin
                    $error("invertible expected %b got %b", exp_inv.invertible, m_tuser[0]);
                    errors++;
                end
            end
        end
    end

    // Abort when nothing moves for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WD_MAX) begin
            $display("affine_matrix_inverse regression: fail");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_random(600, 0, 0);
        test_random(450, 73, 0);
        test_random(450, 0, 73);
        test_random(400, 9, 9);
        test_backpressure();
        repeat (LAT + 10) @(posedge aclk);
        if (errors == 0 && inverse_q.size() == 0) begin
            $display("affine_matrix_inverse regression: pass");
        end else begin
            $display("affine_matrix_inverse regression: fail");
        end
        $finish;
    end

endmodule
